[hw/rtl/lrow_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrow_pkg
// Shared widths, reset values, register indexes and the cell control bundle
// for the recency chain with watermark eviction.
// ----------------------------------------------------------------------------
package lrow_pkg;

  localparam int ID_W        = 6;
  localparam int LVL_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int ID_SPACE    = 1 << ID_W;
  localparam int ENTRIES_DEF = 64;

  localparam logic [LVL_W-1:0] ACTIVATE_RST = 7'd48;
  localparam logic [LVL_W-1:0] CLEAN_RST    = 7'd32;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAN    = 2'd1;

  typedef struct packed {
    logic            upd;
    logic            evict;
    logic [ID_W-1:0] key;
  } lrow_ctl_t;

endpackage

[hw/rtl/lrow_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrow_cell
// One slot of the recency chain. Holds an entry number and a valid bit,
// takes its newer neighbor's contents on an update shift and drops out of
// the chain when it is the oldest valid slot during an eviction step.
// ----------------------------------------------------------------------------
module lrow_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lrow_pkg::lrow_ctl_t     ctl,
  input  logic                    prev_valid,
  input  logic [lrow_pkg::ID_W-1:0] prev_id,
  input  logic                    above,
  input  logic                    next_valid,
  output logic                    valid,
  output logic [lrow_pkg::ID_W-1:0] id,
  output logic                    hit,
  output logic                    oldest
);
  import lrow_pkg::*;

  logic            valid_r;
  logic [ID_W-1:0] id_r;

  assign valid  = valid_r;
  assign id     = id_r;
  assign hit    = valid_r && (id_r == ctl.key);
  assign oldest = valid_r && !next_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.upd && !above) begin
      valid_r <= prev_valid;
    end else if (ctl.evict && oldest) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd && !above) begin
      id_r <= prev_id;
    end
  end

endmodule

[hw/rtl/lru_order_with_watermark_eviction.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_order_with_watermark_eviction
// Recency order kept in a row of cells, newest at cell 0. An access shifts the
// cells in front of the hit (or all of them on a miss) one place older and
// puts the entry at cell 0. After a miss that raises the count above both the
// activate and the clean level, the oldest cell is evicted one beat per cycle,
// unless the output stalls, until the count is at most the clean level or zero.
// Order: an access is accepted in S_IDLE and applied in the next cycle, in
//   S_UPDATE; eviction beats are then removed in S_EVICT and registered onto
//   the output.
// Throughput: no new access is taken until the update and all its evictions
//   are done; a single shift per update, one oldest-cell removal per cycle.
// Reset: clears every cell valid bit, the count and the state, no sweep;
//   levels return to 48 and 32.
// ----------------------------------------------------------------------------
module lru_order_with_watermark_eviction #(
  parameter int ENTRIES = lrow_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lrow_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrow_pkg::LVL_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lrow_pkg::ID_W-1:0]    in_entry_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lrow_pkg::ID_W-1:0]    out_evicted_id,
  output logic                         out_last_eviction
);
  import lrow_pkg::*;

  localparam int CELLS = (ENTRIES < ID_SPACE) ? ENTRIES : ID_SPACE;
  localparam int CNT_W = $clog2(CELLS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_EVICT
  } state_t;

  state_t           state_r;
  logic [ID_W-1:0]  key_r;
  logic [CNT_W-1:0] count_r;
  logic [LVL_W-1:0] act_r;
  logic [LVL_W-1:0] clean_r;
  logic             out_valid_r;
  logic [ID_W-1:0]  out_id_r;
  logic             out_last_r;

  lrow_ctl_t        ctl;
  logic             cell_valid  [CELLS];
  logic [ID_W-1:0]  cell_id     [CELLS];
  logic             cell_hit    [CELLS];
  logic             cell_oldest [CELLS];
  logic             cell_above  [CELLS];

  logic             any_hit;
  logic [ID_W-1:0]  oldest_id;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic             evict_step;
  logic             evict_last;
  logic             in_accept;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid         = out_valid_r;
  assign out_evicted_id    = out_id_r;
  assign out_last_eviction = out_last_r;

  assign evict_step = (state_r == S_EVICT) && (!out_valid_r || !out_stall);
  assign cnt_inc    = count_r + CNT_W'(1);
  assign cnt_dec    = count_r - CNT_W'(1);
  assign evict_last = !((LVL_W'(cnt_dec) > clean_r) && (cnt_dec != '0));

  assign ctl.upd   = (state_r == S_UPDATE);
  assign ctl.evict = evict_step;
  assign ctl.key   = key_r;

  // hits ahead of each cell stop its shift
  always_comb begin
    any_hit   = 1'b0;
    oldest_id = '0;
    for (int i = 0; i < CELLS; i++) begin
      cell_above[i] = any_hit;
      any_hit       = any_hit | cell_hit[i];
      oldest_id     = oldest_id | (cell_oldest[i] ? cell_id[i] : '0);
    end
  end

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    logic            pv;
    logic [ID_W-1:0] pid;
    logic            nv;
    if (g == 0) begin : g_head
      assign pv  = 1'b1;
      assign pid = key_r;
    end else begin : g_body
      assign pv  = cell_valid[g-1];
      assign pid = cell_id[g-1];
    end
    if (g == CELLS - 1) begin : g_tail
      assign nv = 1'b0;
    end else begin : g_inner
      assign nv = cell_valid[g+1];
    end
    lrow_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_valid (pv),
      .prev_id    (pid),
      .above      (cell_above[g]),
      .next_valid (nv),
      .valid      (cell_valid[g]),
      .id         (cell_id[g]),
      .hit        (cell_hit[g]),
      .oldest     (cell_oldest[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= ACTIVATE_RST;
      clean_r <= CLEAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVATE: act_r   <= cfg_wdata;
        REG_CLEAN:    clean_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (evict_step) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept && (32'(in_entry_id) < ENTRIES)) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (any_hit) begin
            state_r <= S_IDLE;
          end else begin
            count_r <= cnt_inc;
            if ((LVL_W'(cnt_inc) > act_r) && (LVL_W'(cnt_inc) > clean_r)) begin
              state_r <= S_EVICT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_EVICT: begin
          if (evict_step) begin
            count_r <= cnt_dec;
            if (evict_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_r <= in_entry_id;
    end
    if (evict_step) begin
      out_id_r   <= oldest_id;
      out_last_r <= evict_last;
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the recency list with watermark eviction. A driver
// feeds entry accesses from a queue, a monitor keeps its own recency order
// and level settings, turns every accepted access into the evictions it must
// cause, and compares each eviction beat against the oldest one still due.
// A short directed run covers hits on oldest, middle and newest positions, the
// eviction corner cases and all register indexes, then random phases with varied
// levels follow.
// ----------------------------------------------------------------------------
module testbench;
  import lrow_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int RANDOM_ITEMS = 224;
  localparam int PHASE_ITEMS = 32;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } eviction_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LVL_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [ID_W-1:0]      in_entry_id;
  logic                 out_valid;
  logic                 out_stall;
  logic [ID_W-1:0]      out_evicted_id;
  logic                 out_last_eviction;

  logic [ID_W-1:0] access_q[$];
  eviction_t       due_evictions[$];
  logic [ID_W-1:0] recency_order[$];
  logic [LVL_W-1:0] act_lvl;
  logic [LVL_W-1:0] cln_lvl;
  logic            in_fire;
  logic            steady;
  int              error_count = 0;

  lru_order_with_watermark_eviction DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_entry_id      (in_entry_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_evicted_id   (out_evicted_id),
    .out_last_eviction(out_last_eviction)
  );

  always #1 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // recency order kept oldest first
  task automatic lru_model_access(input logic [ID_W-1:0] id);
    int hit;
    int n;
    logic [ID_W-1:0] victim;
    hit = -1;
    for (int i = 0; i < recency_order.size(); i++) begin
      if (recency_order[i] == id) hit = i;
    end
    if (hit >= 0) begin
      recency_order.delete(hit);
      recency_order.push_back(id);
    end else begin
      recency_order.push_back(id);
      if (recency_order.size() > int'(act_lvl) && recency_order.size() > int'(cln_lvl)) begin
        n = recency_order.size() - int'(cln_lvl);
        for (int i = 0; i < n; i++) begin
          victim = recency_order.pop_front();
          due_evictions.push_back('{id: victim, last: (i == n - 1)});
        end
      end
    end
  endtask

  always @(posedge clk) begin
    eviction_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) lru_model_access(in_entry_id);
    if (rst_n && out_valid && !out_stall) begin
      if (due_evictions.size() == 0) begin
        flag_mismatch($sformatf("eviction of %0d with none due", out_evicted_id));
      end else begin
        want = due_evictions.pop_front();
        if (out_evicted_id !== want.id)
          flag_mismatch($sformatf("evicted_id %0d, want %0d", out_evicted_id, want.id));
        if (out_last_eviction !== want.last)
          flag_mismatch($sformatf("last_eviction %0b, want %0b on id %0d",
                                  out_last_eviction, want.last, want.id));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_entry_id <= '0;
      out_stall   <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (access_q.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
          in_valid    <= 1'b1;
          in_entry_id <= access_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 7);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_ACTIVATE) act_lvl = val;
    else if (idx == REG_CLEAN) cln_lvl = val;
  endtask

  task automatic set_levels(input logic [LVL_W-1:0] act, input logic [LVL_W-1:0] cln);
    write_reg(REG_ACTIVATE, act);
    write_reg(REG_CLEAN, cln);
    if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                                          LVL_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the list to go quiet, then let an access without evictions finish
  task automatic drain();
    while (access_q.size() != 0 || in_valid || due_evictions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_ids(input logic [ID_W-1:0] ids[]);
    foreach (ids[i]) access_q.push_back(ids[i]);
  endtask

  initial begin
    logic [ID_W-1:0] perm[64];
    logic [ID_W-1:0] tmp;
    logic [ID_W-1:0] hot_base;
    logic [ID_W-1:0] spare_id;
    int j;
    int sent;
    int phase;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_ACTIVATE;
    cfg_wdata   = '0;
    steady      = 1'b0;
    act_lvl     = ACTIVATE_RST;
    cln_lvl     = CLEAN_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset levels: hits on oldest, middle and newest positions
    queue_ids('{6'd0, 6'd63, 6'd0, 6'd42, 6'd21, 6'd63, 6'd42, 6'd42});
    drain();
    // low watermarks, several evictions from one access
    set_levels(7'd3, 7'd1);
    queue_ids('{6'd7, 6'd8, 6'd9, 6'd7});
    drain();
    // clean level above the count: activation without eviction
    set_levels(7'd1, 7'd64);
    queue_ids('{6'd10, 6'd11, 6'd12});
    drain();
    // clean level zero empties the list, new entry included
    set_levels(7'd0, 7'd0);
    queue_ids('{6'd13, 6'd13, 6'h2A});
    drain();
    write_reg(REG_SPARE_LO, 7'h7F);
    write_reg(REG_SPARE_HI, 7'h7F);
    @(negedge clk);
    cfg_we <= 1'b0;
    set_levels(7'd64, 7'd0);
    queue_ids('{6'd15, 6'h2A, 6'd15});
    drain();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS && phase < 40) begin
      steady   = (phase == 3);
      hot_base = ID_W'($urandom);
      if (phase == 0) begin
        // fill all but one entry with eviction disabled
        set_levels(7'h7F, 7'd0);
        for (int i = 0; i < 64; i++) perm[i] = ID_W'(i);
        for (int i = 63; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < 63; i++) access_q.push_back(perm[i]);
        spare_id = perm[63];
        sent += 63;
      end else begin
        if (phase == 1) begin
          // full list then one miss: every entry goes
          set_levels(7'd63, 7'd0);
          access_q.push_back(spare_id);
          sent++;
        end else if ($urandom_range(7) == 0) begin
          set_levels($urandom_range(1) ? 7'd64 : 7'd0, $urandom_range(1) ? 7'd64 : 7'd0);
        end else begin
          set_levels(LVL_W'($urandom_range(64)), LVL_W'($urandom_range(64)));
        end
        repeat (PHASE_ITEMS) begin
          if ($urandom_range(1)) access_q.push_back(ID_W'($urandom));
          else access_q.push_back(hot_base + ID_W'($urandom_range(7)));
        end
        sent += PHASE_ITEMS;
      end
      drain();
      phase++;
    end
    steady = 1'b0;

    if (error_count == 0) begin
      $display("lru_order_with_watermark_eviction verification clean");
    end else begin
      $display("lru_order_with_watermark_eviction verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("lru_order_with_watermark_eviction verification failed");
    $finish;
  end

endmodule
